// ----- src/iksf_pkg.sv -----
// ----------------------------------------------------------------------------
// iksf_pkg
// Shared types, constants and the arctangent table for the segment follow unit.
// ----------------------------------------------------------------------------
package iksf_pkg;

   localparam int DEF_COORD_WIDTH       = 20;
   localparam int DEF_CORDIC_ITERATIONS = 16;

   localparam int LEN_WIDTH      = 16;
   localparam int HEAD_WIDTH     = 16;
   localparam int ANGLE_WIDTH    = 32;
   // angle register carries two guard bits over the 32-bit circle
   localparam int Z_WIDTH        = ANGLE_WIDTH + 2;
   localparam int ATAN_ENTRIES   = 24;
   localparam int ITER_IDX_WIDTH = 5;
   localparam int GAIN_WIDTH     = 30;
   localparam int PROD_WIDTH     = LEN_WIDTH + GAIN_WIDTH;
   // rotated length component after rounding, plus sign
   localparam int CX_WIDTH       = 18;

   localparam logic [GAIN_WIDTH-1:0] GAIN_INV  = 30'd652032874;
   localparam logic [LEN_WIDTH-1:0]  LEN_RESET = 16'd256;

   localparam logic REQ_FOLLOW = 1'b0;
   localparam logic REQ_PLACE  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_VEC,
      ST_VEC_DONE,
      ST_ROT_INIT,
      ST_ROT,
      ST_ROUND,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                      load_req;
      logic                      prep;
      logic                      step;
      logic                      rot;
      logic [ITER_IDX_WIDTH-1:0] iter;
      logic                      head_write;
      logic                      rot_init;
      logic                      round;
      logic                      update;
      logic                      load_out;
   } cmd_type;

   typedef struct packed {
      logic move;
      logic place;
   } status_type;

   // round(atan(2^-i) * 2^32 / (2 pi))
   function automatic logic [ANGLE_WIDTH-1:0] atan_lookup(
      input logic [ITER_IDX_WIDTH-1:0] idx);
      logic [ANGLE_WIDTH-1:0] val;
      unique case (idx)
         5'd0:  val = 32'h2000_0000;
         5'd1:  val = 32'h12E4_051E;
         5'd2:  val = 32'h09FB_385B;
         5'd3:  val = 32'h0511_11D4;
         5'd4:  val = 32'h028B_0D43;
         5'd5:  val = 32'h0145_D7E1;
         5'd6:  val = 32'h00A2_F61E;
         5'd7:  val = 32'h0051_7C55;
         5'd8:  val = 32'h0028_BE53;
         5'd9:  val = 32'h0014_5F2F;
         5'd10: val = 32'h000A_2F98;
         5'd11: val = 32'h0005_17CC;
         5'd12: val = 32'h0002_8BE6;
         5'd13: val = 32'h0001_45F3;
         5'd14: val = 32'h0000_A2FA;
         5'd15: val = 32'h0000_517D;
         5'd16: val = 32'h0000_28BE;
         5'd17: val = 32'h0000_145F;
         5'd18: val = 32'h0000_0A30;
         5'd19: val = 32'h0000_0518;
         5'd20: val = 32'h0000_028C;
         5'd21: val = 32'h0000_0146;
         5'd22: val = 32'h0000_00A3;
         5'd23: val = 32'h0000_0051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- src/iksf_ctrl.sv -----
// ----------------------------------------------------------------------------
// iksf_ctrl
// Sequencer: request intake, cordic iteration count and result handoff.
// ----------------------------------------------------------------------------
module iksf_ctrl #(
   parameter int CORDIC_ITERATIONS = iksf_pkg::DEF_CORDIC_ITERATIONS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  iksf_pkg::status_type status,
   output iksf_pkg::cmd_type    cmd
);
   import iksf_pkg::*;

   localparam int N_EFF = (CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                              : CORDIC_ITERATIONS;
   localparam logic [ITER_IDX_WIDTH-1:0] LAST_ITER = ITER_IDX_WIDTH'(N_EFF - 1);

   state_type                 state_ff, state_in;
   logic [ITER_IDX_WIDTH-1:0] cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      cmd.iter     = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.move ? ST_VEC : ST_ROT_INIT;
         end
         ST_VEC: begin
            cmd.step = 1'b1;
            if (cnt_ff == LAST_ITER) begin
               cnt_in   = '0;
               state_in = ST_VEC_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_VEC_DONE: begin
            cmd.head_write = 1'b1;
            state_in       = ST_ROT_INIT;
         end
         ST_ROT_INIT: begin
            cmd.rot_init = 1'b1;
            state_in     = ST_ROT;
         end
         ST_ROT: begin
            cmd.step = 1'b1;
            cmd.rot  = 1'b1;
            if (cnt_ff == LAST_ITER) begin
               cnt_in   = '0;
               state_in = ST_ROUND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST_ITER)
      else $error("iteration counter past last iteration");

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_VEC || state_ff == ST_ROT) |-> cnt_ff == '0)
      else $error("iteration counter not cleared outside cordic pass");

   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_PREP)
      else $error("accepted request did not start preparation");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_valid_ff && rsp_stall |=> state_ff == ST_DONE)
      else $error("result overwrote an unread response");

   a_place_skip: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PREP && status.place |=> state_ff == ST_ROT_INIT)
      else $error("place request entered vectoring");

endmodule

// ----- src/iksf_datapath.sv -----
// ----------------------------------------------------------------------------
// iksf_datapath
// Segment state, length register, shared cordic unit and output registers.
// ----------------------------------------------------------------------------
module iksf_datapath #(
   parameter int COORD_WIDTH = iksf_pkg::DEF_COORD_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [iksf_pkg::LEN_WIDTH-1:0]        csr_wr_data,
   input  logic                                  req_type,
   input  logic signed [COORD_WIDTH-1:0]         req_target_x,
   input  logic signed [COORD_WIDTH-1:0]         req_target_y,
   input  iksf_pkg::cmd_type                     cmd,
   output iksf_pkg::status_type                  status,
   output logic signed [COORD_WIDTH-1:0]         rsp_base_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_base_y,
   output logic signed [COORD_WIDTH-1:0]         rsp_tip_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_tip_y,
   output logic [iksf_pkg::HEAD_WIDTH-1:0]       rsp_heading,
   output logic                                  rsp_degenerate
);
   import iksf_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;
   localparam int XYW = (CW + 3 > 33) ? CW + 3 : 33;
   localparam int SW  = ((CW > CX_WIDTH) ? CW : CX_WIDTH) + 1;

   // model state
   logic [LEN_WIDTH-1:0]      seg_len_ff, seg_len_in;
   logic signed [CW-1:0]      base_x_ff, base_x_in, base_y_ff, base_y_in;
   logic [HEAD_WIDTH-1:0]     heading_ff, heading_in;
   // request and working registers
   logic                      type_ff, type_in;
   logic signed [CW-1:0]      tx_ff, tx_in, ty_ff, ty_in;
   logic                      degen_ff, degen_in, move_ff, move_in;
   logic [PROD_WIDTH-1:0]     prod_ff, prod_in;
   logic signed [XYW-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [Z_WIDTH-1:0] z_ff, z_in;
   logic                      neg_ff, neg_in;
   logic signed [CX_WIDTH-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CW-1:0]      out_bx_ff, out_bx_in, out_by_ff, out_by_in;
   logic signed [CW-1:0]      out_tx_ff, out_tx_in, out_ty_ff, out_ty_in;
   logic [HEAD_WIDTH-1:0]     out_head_ff, out_head_in;
   logic                      out_degen_ff, out_degen_in;

   // combinational helpers
   logic signed [DW-1:0]      dx, dy;
   logic signed [XYW-1:0]     dx_ext, dy_ext, xs, ys, x_rnd, y_rnd, x_sh, y_sh;
   logic [Z_WIDTH-1:0]        atan_ext;
   logic                      up;
   logic [ANGLE_WIDTH-1:0]    z_rnd, rot_a, rot_diff, rot_a2;
   logic                      rot_wrap;
   logic [PROD_WIDTH-1:0]     x0_sum;
   logic signed [CX_WIDTH-1:0] cx_mag, cy_mag;

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi, lo;
      logic signed [CW-1:0] r;
      hi = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         r = hi[CW-1:0];
      end else if (v < lo) begin
         r = lo[CW-1:0];
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SW-1:0] ext_coord(input logic signed [CW-1:0] v);
      return {{(SW-CW){v[CW-1]}}, v};
   endfunction

   function automatic logic signed [SW-1:0] ext_cx(input logic signed [CX_WIDTH-1:0] v);
      return {{(SW-CX_WIDTH){v[CX_WIDTH-1]}}, v};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_len_ff <= LEN_RESET;
         base_x_ff  <= '0;
         base_y_ff  <= '0;
         heading_ff <= '0;
      end else begin
         seg_len_ff <= seg_len_in;
         base_x_ff  <= base_x_in;
         base_y_ff  <= base_y_in;
         heading_ff <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      degen_ff     <= degen_in;
      move_ff      <= move_in;
      prod_ff      <= prod_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      neg_ff       <= neg_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      out_bx_ff    <= out_bx_in;
      out_by_ff    <= out_by_in;
      out_tx_ff    <= out_tx_in;
      out_ty_ff    <= out_ty_in;
      out_head_ff  <= out_head_in;
      out_degen_ff <= out_degen_in;
   end

   always_comb begin
      dx     = {tx_ff[CW-1], tx_ff} - {base_x_ff[CW-1], base_x_ff};
      dy     = {ty_ff[CW-1], ty_ff} - {base_y_ff[CW-1], base_y_ff};
      dx_ext = {{(XYW-DW){dx[DW-1]}}, dx};
      dy_ext = {{(XYW-DW){dy[DW-1]}}, dy};

      status.place = (type_ff == REQ_PLACE);
      status.move  = (type_ff == REQ_FOLLOW) && ((dx != '0) || (dy != '0));

      // one cordic step, shared by vectoring and rotation
      xs       = x_ff >>> cmd.iter;
      ys       = y_ff >>> cmd.iter;
      atan_ext = {{(Z_WIDTH-ANGLE_WIDTH){1'b0}}, atan_lookup(cmd.iter)};
      up       = cmd.rot ? z_ff[Z_WIDTH-1] : ~y_ff[XYW-1];

      z_rnd = z_ff[ANGLE_WIDTH-1:0] + 32'h0000_8000;

      // angles in the left half plane turn by half a circle, result negated
      rot_a    = {heading_ff, {(ANGLE_WIDTH-HEAD_WIDTH){1'b0}}};
      rot_diff = rot_a - 32'h4000_0000;
      rot_wrap = (rot_diff < 32'h8000_0000);
      rot_a2   = rot_wrap ? rot_a + 32'h8000_0000 : rot_a;
      x0_sum   = prod_ff + PROD_WIDTH'(32768);

      x_rnd  = x_ff + XYW'(8192);
      y_rnd  = y_ff + XYW'(8192);
      x_sh   = x_rnd >>> 14;
      y_sh   = y_rnd >>> 14;
      cx_mag = x_sh[CX_WIDTH-1:0];
      cy_mag = y_sh[CX_WIDTH-1:0];
   end

   always_comb begin
      seg_len_in   = seg_len_ff;
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      heading_in   = heading_ff;
      type_in      = type_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      degen_in     = degen_ff;
      move_in      = move_ff;
      prod_in      = prod_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      neg_in       = neg_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      out_bx_in    = out_bx_ff;
      out_by_in    = out_by_ff;
      out_tx_in    = out_tx_ff;
      out_ty_in    = out_ty_ff;
      out_head_in  = out_head_ff;
      out_degen_in = out_degen_ff;

      if (csr_wr_en) begin
         seg_len_in = csr_wr_data;
      end

      if (cmd.load_req) begin
         type_in = req_type;
         tx_in   = req_target_x;
         ty_in   = req_target_y;
      end

      if (cmd.prep) begin
         degen_in = (type_ff == REQ_FOLLOW) && !status.move;
         move_in  = status.move;
         prod_in  = seg_len_ff * GAIN_INV;
         // vectoring start: fold into the right half plane
         if (dx[DW-1]) begin
            x_in = -dx_ext;
            y_in = -dy_ext;
            z_in = {{(Z_WIDTH-ANGLE_WIDTH){1'b0}}, 32'h8000_0000};
         end else begin
            x_in = dx_ext;
            y_in = dy_ext;
            z_in = '0;
         end
         if (status.place) begin
            base_x_in = tx_ff;
            base_y_in = ty_ff;
         end
      end

      if (cmd.step) begin
         if (up) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_ext;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_ext;
         end
      end

      if (cmd.head_write) begin
         heading_in = z_rnd[ANGLE_WIDTH-1 -: HEAD_WIDTH];
      end

      if (cmd.rot_init) begin
         x_in   = {{(XYW-GAIN_WIDTH){1'b0}}, x0_sum[PROD_WIDTH-1 -: GAIN_WIDTH]};
         y_in   = '0;
         z_in   = {{(Z_WIDTH-ANGLE_WIDTH){rot_a2[ANGLE_WIDTH-1]}}, rot_a2};
         neg_in = rot_wrap;
      end

      if (cmd.round) begin
         cx_in = neg_ff ? -cx_mag : cx_mag;
         cy_in = neg_ff ? -cy_mag : cy_mag;
      end

      if (cmd.update && move_ff) begin
         base_x_in = sat_coord(ext_coord(tx_ff) - ext_cx(cx_ff));
         base_y_in = sat_coord(ext_coord(ty_ff) - ext_cx(cy_ff));
      end

      if (cmd.load_out) begin
         out_bx_in    = base_x_ff;
         out_by_in    = base_y_ff;
         out_tx_in    = sat_coord(ext_coord(base_x_ff) + ext_cx(cx_ff));
         out_ty_in    = sat_coord(ext_coord(base_y_ff) + ext_cx(cy_ff));
         out_head_in  = heading_ff;
         out_degen_in = degen_ff;
      end
   end

   assign rsp_base_x     = out_bx_ff;
   assign rsp_base_y     = out_by_ff;
   assign rsp_tip_x      = out_tx_ff;
   assign rsp_tip_y      = out_ty_ff;
   assign rsp_heading    = out_head_ff;
   assign rsp_degenerate = out_degen_ff;

endmodule

// ----- src/ik_segment_follow_unit.sv -----
// ----------------------------------------------------------------------------
// ik_segment_follow_unit
// One rigid segment that follows a target point, with cordic heading and tip.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: req_type 0 follows req_target_x/y, 1 places
//   the base there. A request is taken when req_valid is high and req_stall
//   is low; req_stall stays high from acceptance until the result is loaded.
//   rsp_* carries base, tip, heading and the degenerate flag, one response
//   per request, taken when rsp_valid is high and rsp_stall is low.
//   csr_wr_en/csr_wr_data write the segment length (4 fraction bits); write
//   it only while no request is in flight.
// Sequence, with N = min(CORDIC_ITERATIONS, 24):
//   a follow request runs a vectoring pass and a rotation pass of N steps
//   each on the one shared cordic stage; a place request or a target on
//   the base needs only the rotation pass. The cordic stage iterates one
//   step per cycle.
// Reset: base and heading clear to zero, segment length to 256 (16.0).
// A stalled response holds in the output register; the next request is
// taken and worked on meanwhile and waits at the end until it drains.
// ----------------------------------------------------------------------------
module ik_segment_follow_unit #(
   parameter int COORD_WIDTH       = iksf_pkg::DEF_COORD_WIDTH,
   parameter int CORDIC_ITERATIONS = iksf_pkg::DEF_CORDIC_ITERATIONS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [iksf_pkg::LEN_WIDTH-1:0]  csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic signed [COORD_WIDTH-1:0]   req_target_x,
   input  logic signed [COORD_WIDTH-1:0]   req_target_y,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [COORD_WIDTH-1:0]   rsp_base_x,
   output logic signed [COORD_WIDTH-1:0]   rsp_base_y,
   output logic signed [COORD_WIDTH-1:0]   rsp_tip_x,
   output logic signed [COORD_WIDTH-1:0]   rsp_tip_y,
   output logic [iksf_pkg::HEAD_WIDTH-1:0] rsp_heading,
   output logic                            rsp_degenerate
);
   import iksf_pkg::*;

   cmd_type    cmd;
   status_type status;

   iksf_ctrl #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   iksf_datapath #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_type       (req_type),
      .req_target_x   (req_target_x),
      .req_target_y   (req_target_y),
      .cmd            (cmd),
      .status         (status),
      .rsp_base_x     (rsp_base_x),
      .rsp_base_y     (rsp_base_y),
      .rsp_tip_x      (rsp_tip_x),
      .rsp_tip_y      (rsp_tip_y),
      .rsp_heading    (rsp_heading),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

// ----- bench/ik_segment_follow_unit_test.sv -----
// ----------------------------------------------------------------------------
// ik_segment_follow_unit_test
// Self-checking bench for the segment follow unit: a directed table of place and
// follow requests, then random request streams over several segment lengths,
// each response checked against its typed pose or a bit-accurate cordic predictor.
// ----------------------------------------------------------------------------
module ik_segment_follow_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import iksf_pkg::*;

   localparam int CW    = DEF_COORD_WIDTH;
   localparam int ITERS = (DEF_CORDIC_ITERATIONS > ATAN_ENTRIES) ?
                          ATAN_ENTRIES : DEF_CORDIC_ITERATIONS;
   localparam longint GAIN_Q30 = 64'd652032874;
   localparam longint CMAX_L   = (longint'(1) << (CW - 1)) - 1;
   localparam longint CMIN_L   = -CMAX_L - 1;

   localparam logic signed [CW-1:0] CMAX    = CW'(CMAX_L);
   localparam logic signed [CW-1:0] CMIN    = CW'(CMIN_L);
   localparam logic signed [CW-1:0] CMAX_M1 = CW'(CMAX_L - 1);
   localparam logic signed [CW-1:0] C0      = '0;

   // atan(2^-i) on a 2^32 circle
   localparam logic [31:0] ARC_TAB [24] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
   };

   typedef struct packed {
      logic signed [CW-1:0]  base_x;
      logic signed [CW-1:0]  base_y;
      logic signed [CW-1:0]  tip_x;
      logic signed [CW-1:0]  tip_y;
      logic [HEAD_WIDTH-1:0] heading;
      logic                  degenerate;
   } pose_type;

   typedef struct packed {
      logic [LEN_WIDTH-1:0] seg_len;
      logic                 kind;
      logic signed [CW-1:0] tx;
      logic signed [CW-1:0] ty;
      logic                 typed;
      pose_type             pose;
   } plan_row_type;

   localparam pose_type NO_POSE = '0;
   localparam int NUM_ROWS      = 25;

   // typed rows are read straight off the behavior; the others go to the predictor
   plan_row_type plan [NUM_ROWS] = '{
      '{16'd256,   REQ_FOLLOW, C0,      C0,      1'b0, NO_POSE},
      '{16'd0,     REQ_FOLLOW, C0,      C0,      1'b1, '{C0, C0, C0, C0, 16'h0000, 1'b1}},
      '{16'd0,     REQ_PLACE,  CMAX,    CMIN,    1'b1,
        '{CMAX, CMIN, CMAX, CMIN, 16'h0000, 1'b0}},
      '{16'd0,     REQ_FOLLOW, CMAX,    CMIN,    1'b1,
        '{CMAX, CMIN, CMAX, CMIN, 16'h0000, 1'b1}},
      '{16'd0,     REQ_PLACE,  CMIN,    CMAX,    1'b1,
        '{CMIN, CMAX, CMIN, CMAX, 16'h0000, 1'b0}},
      '{16'd0,     REQ_PLACE,  C0,      C0,      1'b1, '{C0, C0, C0, C0, 16'h0000, 1'b0}},
      '{16'd0,     REQ_FOLLOW, CW'(160), C0,     1'b0, NO_POSE},
      '{16'd0,     REQ_FOLLOW, CMIN,    CMIN,    1'b0, NO_POSE},
      '{16'd256,   REQ_PLACE,  C0,      C0,      1'b0, NO_POSE},
      '{16'd256,   REQ_FOLLOW, C0,      CW'(1600), 1'b0, NO_POSE},
      '{16'd256,   REQ_FOLLOW, CW'(-4096), CW'(1344), 1'b0, NO_POSE},
      '{16'd256,   REQ_FOLLOW, C0,      CMIN,    1'b0, NO_POSE},
      '{16'd256,   REQ_FOLLOW, CMAX,    CMAX,    1'b0, NO_POSE},
      '{16'd256,   REQ_FOLLOW, CMIN,    CMAX,    1'b0, NO_POSE},
      '{16'd65535, REQ_PLACE,  CMAX,    C0,      1'b0, NO_POSE},
      // heading turns half a circle, base is pushed past the top
      '{16'd65535, REQ_FOLLOW, CMAX_M1, C0,      1'b0, NO_POSE},
      '{16'd65535, REQ_PLACE,  CMAX,    CMAX,    1'b0, NO_POSE},
      '{16'd65535, REQ_FOLLOW, CMIN,    CMIN,    1'b0, NO_POSE},
      '{16'd65535, REQ_FOLLOW, CMAX,    CMIN,    1'b0, NO_POSE},
      '{16'd65535, REQ_PLACE,  CMIN,    CMIN,    1'b0, NO_POSE},
      '{16'd65535, REQ_FOLLOW, CMIN,    CMIN,    1'b0, NO_POSE},
      '{16'd1,     REQ_FOLLOW, CW'(1),  CW'(-1), 1'b0, NO_POSE},
      '{16'd1,     REQ_FOLLOW, CW'(-1), CW'(1),  1'b0, NO_POSE},
      '{16'd1,     REQ_PLACE,  CW'(-1), CW'(-1), 1'b0, NO_POSE},
      '{16'd1,     REQ_FOLLOW, CW'(-1), CW'(-2), 1'b0, NO_POSE}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [LEN_WIDTH-1:0]  csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_type = REQ_FOLLOW;
   logic signed [CW-1:0]  req_target_x = '0;
   logic signed [CW-1:0]  req_target_y = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [CW-1:0]  rsp_base_x;
   logic signed [CW-1:0]  rsp_base_y;
   logic signed [CW-1:0]  rsp_tip_x;
   logic signed [CW-1:0]  rsp_tip_y;
   logic [HEAD_WIDTH-1:0] rsp_heading;
   logic                  rsp_degenerate;

   // predicted segment state
   longint               seg_base_x = 0;
   longint               seg_base_y = 0;
   logic [HEAD_WIDTH-1:0] seg_heading = '0;
   logic [LEN_WIDTH-1:0] seg_length = LEN_RESET;

   pose_type pending_poses [$];
   int       mismatch_count = 0;
   int       burst_left = 0;

   ik_segment_follow_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_target_x   (req_target_x),
      .req_target_y   (req_target_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_base_x     (rsp_base_x),
      .rsp_base_y     (rsp_base_y),
      .rsp_tip_x      (rsp_tip_x),
      .rsp_tip_y      (rsp_tip_y),
      .rsp_heading    (rsp_heading),
      .rsp_degenerate (rsp_degenerate)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("[ik_segment_follow_unit] ERROR");
      $finish;
   end

   function automatic logic signed [CW-1:0] clamp_coord(longint v);
      if (v > CMAX_L) return CMAX;
      if (v < CMIN_L) return CMIN;
      return v[CW-1:0];
   endfunction

   // vectoring pass: angle of (dx, dy), rounded to 16 bits
   function automatic logic [HEAD_WIDTH-1:0] cordic_heading(longint dx, longint dy);
      longint      x, y, xs, ys;
      logic [31:0] z, zr;
      int          i;
      x = dx;
      y = dy;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (i = 0; i < ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARC_TAB[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARC_TAB[i];
         end
      end
      zr = z + 32'h0000_8000;
      return zr[31:16];
   endfunction

   // rotation pass: segment length times (cos, sin) of the heading
   function automatic void cordic_reach(logic [HEAD_WIDTH-1:0] head,
                                        output longint cx, output longint cy);
      logic [31:0] a, off;
      logic        flip;
      longint      r, x, y, xs, ys;
      int          i;
      a = {head, 16'h0000};
      off = a - 32'h4000_0000;
      // left half plane: turn by half a circle and negate at the end
      flip = (off < 32'h8000_0000);
      if (flip) a = a + 32'h8000_0000;
      r = longint'($signed(a));
      x = (longint'(seg_length) * GAIN_Q30 + 32768) >>> 16;
      y = 0;
      for (i = 0; i < ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (r >= 0) begin
            x = x - ys;
            y = y + xs;
            r = r - longint'(ARC_TAB[i]);
         end else begin
            x = x + ys;
            y = y - xs;
            r = r + longint'(ARC_TAB[i]);
         end
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      cx = flip ? -x : x;
      cy = flip ? -y : y;
   endfunction

   function automatic pose_type follow_segment(logic kind, logic signed [CW-1:0] tx,
                                               logic signed [CW-1:0] ty);
      pose_type res;
      longint   cx, cy, dx, dy;
      logic     move;
      move = 1'b0;
      res.degenerate = 1'b0;
      if (kind == REQ_PLACE) begin
         seg_base_x = longint'(tx);
         seg_base_y = longint'(ty);
      end else begin
         dx = longint'(tx) - seg_base_x;
         dy = longint'(ty) - seg_base_y;
         if (dx == 0 && dy == 0) begin
            res.degenerate = 1'b1;
         end else begin
            seg_heading = cordic_heading(dx, dy);
            move = 1'b1;
         end
      end
      cordic_reach(seg_heading, cx, cy);
      if (move) begin
         seg_base_x = clamp_coord(longint'(tx) - cx);
         seg_base_y = clamp_coord(longint'(ty) - cy);
      end
      res.base_x  = seg_base_x[CW-1:0];
      res.base_y  = seg_base_y[CW-1:0];
      res.tip_x   = clamp_coord(seg_base_x + cx);
      res.tip_y   = clamp_coord(seg_base_y + cy);
      res.heading = seg_heading;
      return res;
   endfunction

   function automatic logic signed [CW-1:0] pick_coord();
      logic [31:0] u;
      u = $urandom();
      case ($urandom_range(0, 7))
         0: return CMAX;
         1: return CMIN;
         2: return C0;
         3: return CW'(longint'($urandom_range(0, 64)) - 32);
         default: return u[CW-1:0];
      endcase
   endfunction

   function automatic logic signed [CW-1:0] near_base(longint origin);
      longint span;
      span = longint'(1) << $urandom_range(0, CW - 1);
      return clamp_coord(origin + longint'($urandom_range(0, 32'(2 * span))) - span);
   endfunction

   // sender works in bursts; called at a rising edge, returns at the acceptance edge
   task automatic issue_request(input logic kind, input logic signed [CW-1:0] tx,
                                input logic signed [CW-1:0] ty, input logic typed,
                                input pose_type typed_pose);
      pose_type want;
      int       gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_target_x <= tx;
      req_target_y <= ty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = follow_segment(kind, tx, ty);
      pending_poses.push_back(typed ? typed_pose : want);
   endtask

   // length is written only with the unit idle
   task automatic apply_length(input logic [LEN_WIDTH-1:0] len);
      req_valid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      seg_length = len;
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int                   k, phase, n, pick;
      logic [LEN_WIDTH-1:0] len;
      logic                 kind;
      logic signed [CW-1:0] tx, ty;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < NUM_ROWS; k++) begin
         if (plan[k].seg_len != seg_length) apply_length(plan[k].seg_len);
         issue_request(plan[k].kind, plan[k].tx, plan[k].ty, plan[k].typed,
                       plan[k].pose);
      end

      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: len = 16'd256;
            1: len = 16'd0;
            2: len = 16'hFFFF;
            3: len = 16'd1;
            4, 5: len = LEN_WIDTH'($urandom_range(1, 2048));
            6: len = LEN_WIDTH'($urandom_range(0, 65535));
            7: len = 16'hFFFF;
            default: len = LEN_WIDTH'($urandom_range(16, 512));
         endcase
         apply_length(len);
         for (n = 0; n < 50; n++) begin
            pick = $urandom_range(0, 99);
            kind = REQ_FOLLOW;
            if (pick < 20) begin
               kind = REQ_PLACE;
               tx = pick_coord();
               ty = pick_coord();
            end else if (pick < 28) begin
               // target on the base
               tx = seg_base_x[CW-1:0];
               ty = seg_base_y[CW-1:0];
            end else if (pick < 75) begin
               tx = near_base(seg_base_x);
               ty = near_base(seg_base_y);
            end else begin
               tx = pick_coord();
               ty = pick_coord();
            end
            issue_request(kind, tx, ty, 1'b0, NO_POSE);
         end
      end

      req_valid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_poses.size() == 0) begin
         $display("[ik_segment_follow_unit] OK");
      end else begin
         $display("[ik_segment_follow_unit] ERROR");
      end
      $finish;
   end

   // receiver stall pattern: modes of random length, from free running to held
   int         stall_hold = 0;
   logic [1:0] stall_mode = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else begin
         if (stall_hold == 0) begin
            stall_hold <= $urandom_range(1, 60);
            stall_mode <= 2'($urandom_range(0, 3));
         end else begin
            stall_hold <= stall_hold - 1;
         end
         case (stall_mode)
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      pose_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_base_x, rsp_base_y, rsp_tip_x, rsp_tip_y, rsp_heading, rsp_degenerate};
         if (pending_poses.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected response: base (%0d,%0d) tip (%0d,%0d) heading %0h",
                        got.base_x, got.base_y, got.tip_x, got.tip_y, got.heading);
            mismatch_count++;
         end else begin
            want = pending_poses.pop_front();
            if (got !== want) begin
               if (mismatch_count < 10) begin
                  $display("response mismatch: base (%0d,%0d) tip (%0d,%0d) heading %0h deg %0b",
                           got.base_x, got.base_y, got.tip_x, got.tip_y, got.heading,
                           got.degenerate);
                  $display("   expected:        base (%0d,%0d) tip (%0d,%0d) heading %0h deg %0b",
                           want.base_x, want.base_y, want.tip_x, want.tip_y, want.heading,
                           want.degenerate);
               end
               mismatch_count++;
            end
         end
      end
   end

endmodule

// ----- sim.f -----
src/iksf_pkg.sv
src/iksf_ctrl.sv
src/iksf_datapath.sv
src/ik_segment_follow_unit.sv
bench/ik_segment_follow_unit_test.sv
